### hdl/mwf_pkg.sv
// Package with the shared types, constants and codes of the mutex with waiter FIFO.
package mwf_pkg;

  localparam int unsigned WAITER_DEPTH  = 16;
  localparam int unsigned TASK_W        = 8;
  localparam int unsigned QUEUE_LEVEL_W = 5;
  localparam int unsigned PTR_W   = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(WAITER_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_LOCK   = 2'd0,
    CMD_TRY    = 2'd1,
    CMD_UNLOCK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_TRYFAIL  = 3'd3,
    ST_RELEASED = 3'd4
  } status_e;

  typedef enum logic {
    CS_EMPTY,
    CS_HOLD
  } ctl_state_e;

  // Actions for the datapath, valid in the cycle a command beat is accepted.
  typedef struct packed {
    logic    load;
    logic    set_held;
    logic    clr_held;
    logic    push;
    logic    pop;
    status_e res_status;
  } dp_ctrl_t;

  typedef struct packed {
    logic held;
    logic empty;
    logic full;
  } dp_status_t;

endpackage

### hdl/mutex_with_waiter_fifo_unit.sv
// Top level of the hardware mutex with a FIFO of waiting task ids.
//
// Each command beat (lock, try lock or unlock with a task id) yields exactly one
// result beat. A command is decided and applied in the cycle it is accepted and
// its result is held in one output register, so the unit takes one command per
// clock as long as the result side keeps up; a stalled result beat holds off
// further commands. The wait queue is a 16-entry ring of task ids with head and
// tail pointers; reset empties it at once, with no clearing pass.
module mutex_with_waiter_fifo_unit
  import mwf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] task_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] wake_task, [8] is_locked,
                                      // [13:9] queue_level, [15:14] zero
  output logic [3:0]  m_axis_tuser    // [2:0] status, [3] wake_valid
);

  dp_ctrl_t                 dp_ctrl;
  dp_status_t               dp_status;
  logic [2:0]               status;
  logic                     wake_valid;
  logic [TASK_W-1:0]        wake_task;
  logic                     is_locked;
  logic [QUEUE_LEVEL_W-1:0] queue_level;

  mwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .command_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .dp_status_i (dp_status),
    .dp_ctrl_o   (dp_ctrl)
  );

  mwf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dp_ctrl_i     (dp_ctrl),
    .dp_status_o   (dp_status),
    .task_id_i     (s_axis_tdata),
    .status_o      (status),
    .wake_valid_o  (wake_valid),
    .wake_task_o   (wake_task),
    .is_locked_o   (is_locked),
    .queue_level_o (queue_level)
  );

  assign m_axis_tdata = {2'b00, queue_level, is_locked, wake_task};
  assign m_axis_tuser = {wake_valid, status};

endmodule

### hdl/mwf_ctrl.sv
// Controller: output slot state machine and command decode into datapath actions.
module mwf_ctrl
  import mwf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t dp_status_i,
  output dp_ctrl_t   dp_ctrl_o
);

  ctl_state_e state_q, state_d;
  logic       accept;
  cmd_e       cmd;

  assign cmd = cmd_e'(command_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_ready_o  = (state_q == CS_EMPTY) || out_ready_i;
    out_valid_o = (state_q == CS_HOLD);
    accept      = in_valid_i && in_ready_o;

    state_d = state_q;
    case (state_q)
      CS_EMPTY: begin
        if (accept) state_d = CS_HOLD;
      end
      CS_HOLD: begin
        if (!accept && out_ready_i) state_d = CS_EMPTY;
      end
      default: state_d = CS_EMPTY;
    endcase

    dp_ctrl_o            = '0;
    dp_ctrl_o.load       = accept;
    dp_ctrl_o.res_status = ST_TRYFAIL;
    case (cmd)
      CMD_LOCK: begin
        if (!dp_status_i.held) begin
          dp_ctrl_o.set_held   = accept;
          dp_ctrl_o.res_status = ST_GRANTED;
        end else if (!dp_status_i.full) begin
          dp_ctrl_o.push       = accept;
          dp_ctrl_o.res_status = ST_QUEUED;
        end else begin
          dp_ctrl_o.res_status = ST_FULL;
        end
      end
      CMD_TRY: begin
        if (!dp_status_i.held) begin
          dp_ctrl_o.set_held   = accept;
          dp_ctrl_o.res_status = ST_GRANTED;
        end
      end
      CMD_UNLOCK: begin
        dp_ctrl_o.clr_held   = accept;
        dp_ctrl_o.pop        = accept && !dp_status_i.empty;
        dp_ctrl_o.res_status = ST_RELEASED;
      end
      default: begin
        // The unused command code changes nothing and reports a failed try.
        dp_ctrl_o.res_status = ST_TRYFAIL;
      end
    endcase
  end

  a_load_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl_o.load |=> out_valid_o)
    else $error("accepted command did not produce a result beat");

  a_no_load_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !dp_ctrl_o.load)
    else $error("command accepted while result slot is stalled");

  a_held_set_xor_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_ctrl_o.set_held && dp_ctrl_o.clr_held))
    else $error("lock flag set and cleared together");

endmodule

### hdl/mwf_datapath.sv
// Datapath: lock flag, ring FIFO of waiting task ids and the result register.
module mwf_datapath
  import mwf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_ctrl_t                 dp_ctrl_i,
  output dp_status_t               dp_status_o,
  input  logic [TASK_W-1:0]        task_id_i,
  output logic [2:0]               status_o,
  output logic                     wake_valid_o,
  output logic [TASK_W-1:0]        wake_task_o,
  output logic                     is_locked_o,
  output logic [QUEUE_LEVEL_W-1:0] queue_level_o
);

  logic                     held_q, held_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic [PTR_W-1:0]         head_q, head_d;
  logic [PTR_W-1:0]         tail_q, tail_d;
  logic [TASK_W-1:0]        queue_q [WAITER_DEPTH];

  logic [2:0]               status_q;
  logic                     wake_valid_q;
  logic [TASK_W-1:0]        wake_task_q, wake_task_d;
  logic                     locked_q;
  logic [QUEUE_LEVEL_W-1:0] level_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(WAITER_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign dp_status_o.held  = held_q;
  assign dp_status_o.empty = (count_q == '0);
  assign dp_status_o.full  = (count_q == COUNT_W'(WAITER_DEPTH));

  always_comb begin
    held_d = held_q;
    if (dp_ctrl_i.set_held) held_d = 1'b1;
    if (dp_ctrl_i.clr_held) held_d = 1'b0;

    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    if (dp_ctrl_i.push) begin
      count_d = count_d + COUNT_W'(1);
      tail_d  = ptr_next(tail_q);
    end
    if (dp_ctrl_i.pop) begin
      count_d = count_d - COUNT_W'(1);
      head_d  = ptr_next(head_q);
    end

    wake_task_d = dp_ctrl_i.pop ? queue_q[head_q] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      held_q  <= held_d;
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_ctrl_i.push) begin
      queue_q[tail_q] <= task_id_i;
    end
    if (dp_ctrl_i.load) begin
      status_q     <= dp_ctrl_i.res_status;
      wake_valid_q <= dp_ctrl_i.pop;
      wake_task_q  <= wake_task_d;
      locked_q     <= held_d;
      level_q      <= QUEUE_LEVEL_W'(count_d);
    end
  end

  assign status_o      = status_q;
  assign wake_valid_o  = wake_valid_q;
  assign wake_task_o   = wake_task_q;
  assign is_locked_o   = locked_q;
  assign queue_level_o = level_q;

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl_i.pop |-> !dp_status_o.empty)
    else $error("pop from an empty waiter queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_ctrl_i.push |-> !dp_status_o.full)
    else $error("push into a full waiter queue");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(WAITER_DEPTH))
    else $error("waiter count beyond queue depth");

  a_count_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_ctrl_i.push && !dp_ctrl_i.pop) |=> (count_q == $past(count_q) + COUNT_W'(1)))
    else $error("waiter count did not follow a push");

endmodule
